// ===== hw/rtl/jscws_pkg.sv =====
// Shared types, character codes and helpers for the JavaScript comment/whitespace stripper.
`default_nettype none

package jscws_pkg;

    typedef enum logic [2:0] {
        SC_START,
        SC_SLASH,
        SC_SPACE,
        SC_BLOCK,
        SC_BLOCK_STAR,
        SC_LINE,
        SC_STR,
        SC_STR_ESC
    } scan_state_t;

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Space, tab, newline, vertical tab, form feed, carriage return.
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/javascript_comment_whitespace_stripper_unit.sv =====
// Top level of the JavaScript comment and whitespace stripper: scanner and result buffer.
//
//  channel | ports                                    | dir | beat
//  --------+------------------------------------------+-----+---------------------------------
//  input   | s_valid, s_ready, s_in_byte[7:0]         | in  | one source byte
//  result  | m_valid, m_ready, m_out_byte[7:0],       | out | one emitted byte, last flag on
//          | m_last_of_run                            |     | the final byte of an input
//
//  Path: an input beat is registered in the input stage when taken and is scanned once the
//  result buffer can take its results; those results are registered in the result buffer.
//  Rate: one input byte per cycle while m_ready is high and each yields at most one result;
//  an input with two results holds the scanner until the first leaves the two-entry buffer.
//  Reset: aresetn (synchronous, active low) returns the scanner to its start state and
//  empties both stages.
//  Stalls: m_ready low holds the result buffer; s_ready drops while the held input byte
//  cannot move into the result buffer.
`default_nettype none

module javascript_comment_whitespace_stripper_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_last_of_run
);

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // scanner state
    jscws_pkg::scan_state_t state_reg, state_next;
    logic                   quote_single_reg, quote_single_next;

    // result of one scan step
    logic [1:0] res_cnt;
    logic [7:0] res_byte0;
    logic       res_last0;
    logic [7:0] res_byte1;

    // two-entry result buffer, head at entry 0
    logic [7:0] ob_byte_reg [2];
    logic       ob_last_reg [2];
    logic [7:0] ob_byte_next [2];
    logic       ob_last_next [2];
    logic [1:0] ob_cnt_reg, ob_cnt_next;

    logic       pop;
    logic       stage_adv;
    logic [7:0] delim;
    logic [7:0] c;

    assign c     = in_byte_reg;
    assign delim = quote_single_reg ? jscws_pkg::CH_SQUOTE : jscws_pkg::CH_DQUOTE;

    assign m_valid       = (ob_cnt_reg != 2'd0);
    assign m_out_byte    = ob_byte_reg[0];
    assign m_last_of_run = ob_last_reg[0];
    assign pop           = m_valid && m_ready;

    // advance only when the buffer is empty after this cycle's pop
    assign stage_adv = in_valid_reg &&
                       ((ob_cnt_reg == 2'd0) || ((ob_cnt_reg == 2'd1) && m_ready));
    assign s_ready   = !in_valid_reg || stage_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_in_byte;
        end
    end

    // next state
    always_comb begin
        state_next        = state_reg;
        quote_single_next = quote_single_reg;
        unique case (state_reg)
            jscws_pkg::SC_START: begin
                if (c == jscws_pkg::CH_SLASH) begin
                    state_next = jscws_pkg::SC_SLASH;
                end else if (jscws_pkg::is_ws(c)) begin
                    state_next = jscws_pkg::SC_SPACE;
                end else if (jscws_pkg::is_quote(c)) begin
                    quote_single_next = (c == jscws_pkg::CH_SQUOTE);
                    state_next        = jscws_pkg::SC_STR;
                end
            end
            jscws_pkg::SC_SLASH: begin
                if (c == jscws_pkg::CH_STAR) begin
                    state_next = jscws_pkg::SC_BLOCK;
                end else if (c == jscws_pkg::CH_SLASH) begin
                    state_next = jscws_pkg::SC_LINE;
                end else begin
                    state_next = jscws_pkg::SC_START;
                end
            end
            jscws_pkg::SC_SPACE: begin
                if (c == jscws_pkg::CH_SLASH) begin
                    state_next = jscws_pkg::SC_SLASH;
                end else if (!jscws_pkg::is_ws(c)) begin
                    if (jscws_pkg::is_quote(c)) begin
                        quote_single_next = (c == jscws_pkg::CH_SQUOTE);
                        state_next        = jscws_pkg::SC_STR;
                    end else begin
                        state_next = jscws_pkg::SC_START;
                    end
                end
            end
            jscws_pkg::SC_BLOCK: begin
                if (c == jscws_pkg::CH_STAR) begin
                    state_next = jscws_pkg::SC_BLOCK_STAR;
                end
            end
            jscws_pkg::SC_BLOCK_STAR: begin
                if (c == jscws_pkg::CH_SLASH) begin
                    state_next = jscws_pkg::SC_SPACE;
                end else if (c != jscws_pkg::CH_STAR) begin
                    state_next = jscws_pkg::SC_BLOCK;
                end
            end
            jscws_pkg::SC_LINE: begin
                if (c == jscws_pkg::CH_NEWLINE) begin
                    state_next = jscws_pkg::SC_SPACE;
                end
            end
            jscws_pkg::SC_STR: begin
                if (c == jscws_pkg::CH_BACKSLASH) begin
                    state_next = jscws_pkg::SC_STR_ESC;
                end else if (c == delim) begin
                    state_next = jscws_pkg::SC_START;
                end
            end
            jscws_pkg::SC_STR_ESC: begin
                state_next = jscws_pkg::SC_STR;
            end
        endcase
    end

    // outputs of the scan step
    always_comb begin
        res_cnt   = 2'd0;
        res_byte0 = c;
        res_last0 = 1'b1;
        res_byte1 = c;
        unique case (state_reg)
            jscws_pkg::SC_START: begin
                if (c != jscws_pkg::CH_SLASH) begin
                    res_cnt = 2'd1;
                end
            end
            jscws_pkg::SC_SLASH: begin
                if ((c == jscws_pkg::CH_STAR) || (c == jscws_pkg::CH_SLASH)) begin
                    // comment collapses to one space
                    res_cnt   = 2'd1;
                    res_byte0 = jscws_pkg::CH_SPACE;
                end else begin
                    res_cnt   = 2'd2;
                    res_byte0 = jscws_pkg::CH_SLASH;
                    res_last0 = 1'b0;
                end
            end
            jscws_pkg::SC_SPACE: begin
                if ((c != jscws_pkg::CH_SLASH) && !jscws_pkg::is_ws(c)) begin
                    res_cnt = 2'd1;
                end
            end
            jscws_pkg::SC_BLOCK, jscws_pkg::SC_BLOCK_STAR, jscws_pkg::SC_LINE: begin
                res_cnt = 2'd0;
            end
            jscws_pkg::SC_STR: begin
                if (c != jscws_pkg::CH_BACKSLASH) begin
                    res_cnt = 2'd1;
                end
            end
            jscws_pkg::SC_STR_ESC: begin
                res_cnt   = 2'd2;
                res_byte0 = jscws_pkg::CH_BACKSLASH;
                res_last0 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= jscws_pkg::SC_START;
            quote_single_reg <= 1'b0;
        end else if (stage_adv) begin
            state_reg        <= state_next;
            quote_single_reg <= quote_single_next;
        end
    end

    // result buffer: pop shifts the tail forward, an advancing scan reloads the emptied buffer
    always_comb begin
        ob_byte_next = ob_byte_reg;
        ob_last_next = ob_last_reg;
        ob_cnt_next  = ob_cnt_reg;
        if (pop) begin
            ob_byte_next[0] = ob_byte_reg[1];
            ob_last_next[0] = ob_last_reg[1];
            ob_cnt_next     = ob_cnt_reg - 2'd1;
        end
        if (stage_adv) begin
            ob_byte_next[0] = res_byte0;
            ob_last_next[0] = res_last0;
            ob_byte_next[1] = res_byte1;
            ob_last_next[1] = 1'b1;
            ob_cnt_next     = res_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_cnt_reg <= 2'd0;
        end else begin
            ob_cnt_reg <= ob_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ob_byte_reg <= ob_byte_next;
        ob_last_reg <= ob_last_next;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_pair_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (ob_cnt_reg == 2'd2) |-> !ob_last_reg[0])
        else $error("first byte of a pair flagged as last");

    a_single_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (ob_cnt_reg == 2'd1) |-> ob_last_reg[0])
        else $error("lone buffered byte not flagged as last");

    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("second byte of a pair missing");

    a_esc_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_adv && (state_reg == jscws_pkg::SC_STR_ESC)) |=>
            (state_reg == jscws_pkg::SC_STR))
        else $error("escape did not return to string state");

endmodule

`default_nettype wire

// ===== bench/tb_javascript_comment_whitespace_stripper_unit.sv =====
// Self-checking testbench for the JavaScript comment and whitespace stripper unit.
`timescale 1ns / 100ps

module tb_javascript_comment_whitespace_stripper_unit;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } emitted_t;

    // Tracks scanner state and the bytes the block should emit, in order.
    class stripper_scoreboard;
        jscws_pkg::scan_state_t scan;
        logic                   quote_single;
        emitted_t               pending_bytes[$];
        int                     mismatches;

        function new();
            scan = jscws_pkg::SC_START;
            quote_single = 1'b0;
            mismatches = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == jscws_pkg::CH_SPACE ||
                   (c >= jscws_pkg::CH_TAB && c <= jscws_pkg::CH_CR);
        endfunction

        function void push_expected(logic [7:0] c, logic last);
            emitted_t e;
            e.ch = c;
            e.last = last;
            pending_bytes.insert(pending_bytes.size(), e);
        endfunction

        function void open_string(logic [7:0] c);
            quote_single = (c == jscws_pkg::CH_SQUOTE);
            scan = jscws_pkg::SC_STR;
        endfunction

        function void note_input(logic [7:0] c);
            logic [7:0] delim;
            delim = quote_single ? jscws_pkg::CH_SQUOTE : jscws_pkg::CH_DQUOTE;
            case (scan)
                jscws_pkg::SC_START: begin
                    if (c == jscws_pkg::CH_SLASH) begin
                        scan = jscws_pkg::SC_SLASH;
                    end else begin
                        if (is_blank(c)) begin
                            scan = jscws_pkg::SC_SPACE;
                        end else if (c == jscws_pkg::CH_DQUOTE ||
                                     c == jscws_pkg::CH_SQUOTE) begin
                            open_string(c);
                        end
                        push_expected(c, 1'b1);
                    end
                end
                jscws_pkg::SC_SLASH: begin
                    if (c == jscws_pkg::CH_STAR) begin
                        push_expected(jscws_pkg::CH_SPACE, 1'b1);
                        scan = jscws_pkg::SC_BLOCK;
                    end else if (c == jscws_pkg::CH_SLASH) begin
                        push_expected(jscws_pkg::CH_SPACE, 1'b1);
                        scan = jscws_pkg::SC_LINE;
                    end else begin
                        // slash was a plain operator: re-emit it ahead of this byte
                        push_expected(jscws_pkg::CH_SLASH, 1'b0);
                        push_expected(c, 1'b1);
                        scan = jscws_pkg::SC_START;
                    end
                end
                jscws_pkg::SC_SPACE: begin
                    if (c == jscws_pkg::CH_SLASH) begin
                        scan = jscws_pkg::SC_SLASH;
                    end else if (!is_blank(c)) begin
                        push_expected(c, 1'b1);
                        if (c == jscws_pkg::CH_DQUOTE || c == jscws_pkg::CH_SQUOTE) begin
                            open_string(c);
                        end else begin
                            scan = jscws_pkg::SC_START;
                        end
                    end
                end
                jscws_pkg::SC_BLOCK: begin
                    if (c == jscws_pkg::CH_STAR) scan = jscws_pkg::SC_BLOCK_STAR;
                end
                jscws_pkg::SC_BLOCK_STAR: begin
                    if (c == jscws_pkg::CH_SLASH) begin
                        scan = jscws_pkg::SC_SPACE;
                    end else if (c != jscws_pkg::CH_STAR) begin
                        scan = jscws_pkg::SC_BLOCK;
                    end
                end
                jscws_pkg::SC_LINE: begin
                    if (c == jscws_pkg::CH_NEWLINE) scan = jscws_pkg::SC_SPACE;
                end
                jscws_pkg::SC_STR: begin
                    if (c == jscws_pkg::CH_BACKSLASH) begin
                        scan = jscws_pkg::SC_STR_ESC;
                    end else begin
                        push_expected(c, 1'b1);
                        if (c == delim) scan = jscws_pkg::SC_START;
                    end
                end
                default: begin
                    push_expected(jscws_pkg::CH_BACKSLASH, 1'b0);
                    push_expected(c, 1'b1);
                    scan = jscws_pkg::SC_STR;
                end
            endcase
        endfunction

        function void check_result(logic [7:0] ch, logic last);
            emitted_t e;
            if (pending_bytes.size() == 0) begin
                $error("out_byte: nothing expected, actual %h (last_of_run %b)", ch, last);
                mismatches++;
                return;
            end
            e = pending_bytes.pop_front();
            if (ch !== e.ch) begin
                $error("out_byte: expected %h, actual %h", e.ch, ch);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("last_of_run: expected %b, actual %b", e.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last_of_run;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    stripper_scoreboard sb = new();
    logic [7:0] text_bytes[$];

    javascript_comment_whitespace_stripper_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last_of_run(m_last_of_run)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_out_byte, m_last_of_run);
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(b);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] blank_char();
        logic [7:0] blanks[6] = '{jscws_pkg::CH_SPACE, jscws_pkg::CH_TAB,
                                  jscws_pkg::CH_NEWLINE, 8'h0B, 8'h0C, jscws_pkg::CH_CR};
        return blanks[$urandom_range(0, 5)];
    endfunction

    // Printable code character that opens nothing: no slash, no quote.
    function automatic logic [7:0] code_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == jscws_pkg::CH_SLASH || c == jscws_pkg::CH_DQUOTE ||
               c == jscws_pkg::CH_SQUOTE);
        return c;
    endfunction

    function automatic void add_text_byte(input logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    // Append one token-like fragment of source text; mostly well formed.
    task automatic build_fragment();
        logic [7:0] q;
        logic [7:0] c;
        int n;
        n = $urandom_range(0, 8);
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                repeat (n / 2 + 1) add_text_byte(code_char());
            end
            3: begin
                repeat (n / 2 + 1) add_text_byte(blank_char());
            end
            4: begin
                add_text_byte(jscws_pkg::CH_SLASH);
                add_text_byte(jscws_pkg::CH_STAR);
                repeat (n) begin
                    c = 8'($urandom_range(0, 255));
                    // keep the comment open until its proper end most of the time
                    if (c == jscws_pkg::CH_SLASH && $urandom_range(0, 3) != 0) begin
                        c = jscws_pkg::CH_STAR;
                    end
                    add_text_byte(c);
                end
                add_text_byte(jscws_pkg::CH_STAR);
                if ($urandom_range(0, 2) == 0) add_text_byte(jscws_pkg::CH_STAR);
                add_text_byte(jscws_pkg::CH_SLASH);
            end
            5: begin
                add_text_byte(jscws_pkg::CH_SLASH);
                add_text_byte(jscws_pkg::CH_SLASH);
                repeat (n) begin
                    do c = 8'($urandom_range(0, 255)); while (c == jscws_pkg::CH_NEWLINE);
                    add_text_byte(c);
                end
                add_text_byte(jscws_pkg::CH_NEWLINE);
            end
            6: begin
                q = $urandom_range(0, 1) ? jscws_pkg::CH_SQUOTE : jscws_pkg::CH_DQUOTE;
                if ($urandom_range(0, 2) == 0) add_text_byte(blank_char());
                add_text_byte(q);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        add_text_byte(jscws_pkg::CH_BACKSLASH);
                        add_text_byte(8'($urandom_range(0, 255)));
                    end else begin
                        do c = 8'($urandom_range(0, 255));
                        while (c == q || c == jscws_pkg::CH_BACKSLASH);
                        add_text_byte(c);
                    end
                end
                add_text_byte(q);
            end
            7: begin
                add_text_byte(jscws_pkg::CH_SLASH);
                do c = 8'($urandom_range(0, 255));
                while (c == jscws_pkg::CH_SLASH || c == jscws_pkg::CH_STAR);
                add_text_byte(c);
            end
            8: begin
                repeat (n / 3 + 1) add_text_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                repeat (n / 3 + 1) add_text_byte(8'($urandom_range(128, 255)));
            end
        endcase
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int sent;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        sent = 0;
        while (sent < count) begin
            build_fragment();
            while (text_bytes.size() != 0) begin
                send_byte(text_bytes.pop_front());
                sent++;
            end
        end
    endtask

    initial begin
        logic [7:0] directed[$];
        directed = '{8'h00, 8'hFF, jscws_pkg::CH_SPACE, jscws_pkg::CH_TAB,
                     jscws_pkg::CH_DQUOTE, jscws_pkg::CH_BACKSLASH, jscws_pkg::CH_DQUOTE,
                     8'h80, jscws_pkg::CH_DQUOTE, jscws_pkg::CH_SLASH, "x",
                     jscws_pkg::CH_SLASH, jscws_pkg::CH_STAR, jscws_pkg::CH_STAR,
                     jscws_pkg::CH_STAR, "q", jscws_pkg::CH_STAR, jscws_pkg::CH_SLASH,
                     jscws_pkg::CH_SLASH, jscws_pkg::CH_SLASH, "z", jscws_pkg::CH_NEWLINE,
                     jscws_pkg::CH_SQUOTE, jscws_pkg::CH_DQUOTE, jscws_pkg::CH_SQUOTE,
                     jscws_pkg::CH_SLASH, jscws_pkg::CH_SQUOTE, 8'h7F};
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corner bytes, escapes, both comment kinds, quote after blank, slash before quote
        foreach (directed[i]) send_byte(directed[i]);

        run_phase(0, 0, 263);
        run_phase(52, 0, 263);
        run_phase(0, 52, 263);
        run_phase(11, 11, 263);
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
